[rtl/gbhs_pkg.sv]
// gbhs_pkg: types and constants for the greedy boost heap scheduler
// no dependencies
`timescale 1ns / 1ps
package gbhs_pkg;
    localparam int HEAP_DEPTH = 1024;
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int SW = $clog2(HEAP_DEPTH + 1);
    localparam int VW = 30;
    localparam int PW = 48;
    localparam int CW = 20;
    localparam logic [PW-1:0] POWER_MAX = {PW{1'b1}};
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_PUSH_RD, ST_PUSH_CMP, ST_POP_CHK, ST_POP_RD,
        ST_POP_CMP, ST_POP_WR, ST_OUT
    } state_t;

    // controller commands to datapath
    typedef struct packed {
        logic load;       // capture request
        logic push_init;  // start push
        logic push_rd;    // read parent
        logic push_move;  // move parent down
        logic push_done;  // write value at hole
        logic pop_init;   // take top, read last
        logic pop_rd;     // read children
        logic pop_move;   // move child up
        logic pop_done;   // write last at hole
        logic set_fail;
        logic set_ovf;
    } cmd_t;

    // datapath status to controller
    typedef struct packed {
        logic is_hurdle;
        logic failed;
        logic heap_full;
        logic heap_empty;
        logic power_short;
        logic push_at_root;
        logic parent_ge;
        logic pop_no_child;
        logic child_le;
        logic pop_last;
    } stat_t;
endpackage

[rtl/gbhs_if.sv]
// gbhs_if: valid/ready channel carrying a payload
// depends on nothing
`timescale 1ns / 1ps
interface gbhs_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/gbhs_ctrl.sv]
// gbhs_ctrl: sequencer for push, pop and result handoff
// depends on gbhs_pkg
`timescale 1ns / 1ps
module gbhs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  gbhs_pkg::stat_t stat,
    output gbhs_pkg::cmd_t  cmd
);
    import gbhs_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (stat.failed)
                    state_next = ST_OUT;
                else if (!stat.is_hurdle)
                begin
                    if (stat.heap_full)
                    begin
                        cmd.set_ovf = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        cmd.push_init = 1'b1;
                        state_next = ST_PUSH_RD;
                    end
                end
                else
                    state_next = ST_POP_CHK;
            end
            ST_PUSH_RD:
            begin
                if (stat.push_at_root)
                begin
                    cmd.push_done = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.push_rd = 1'b1;
                    state_next = ST_PUSH_CMP;
                end
            end
            ST_PUSH_CMP:
            begin
                if (stat.parent_ge)
                begin
                    cmd.push_done = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.push_move = 1'b1;
                    state_next = ST_PUSH_RD;
                end
            end
            ST_POP_CHK:
            begin
                if (!stat.power_short)
                    state_next = ST_OUT;
                else if (stat.heap_empty)
                begin
                    cmd.set_fail = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.pop_init = 1'b1;
                    state_next = ST_POP_WR;
                end
            end
            ST_POP_WR:
            begin
                // top and last are registered, now sift
                if (stat.pop_last)
                    state_next = ST_POP_CHK;
                else
                    state_next = ST_POP_RD;
            end
            ST_POP_RD:
            begin
                if (stat.pop_no_child)
                begin
                    cmd.pop_done = 1'b1;
                    state_next = ST_POP_CHK;
                end
                else
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = ST_POP_CMP;
                end
            end
            ST_POP_CMP:
            begin
                if (stat.child_le)
                begin
                    cmd.pop_done = 1'b1;
                    state_next = ST_POP_CHK;
                end
                else
                begin
                    cmd.pop_move = 1'b1;
                    state_next = ST_POP_RD;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

[rtl/gbhs_datapath.sv]
// gbhs_datapath: heap memory, power, count and flags
// depends on gbhs_pkg
`timescale 1ns / 1ps
module gbhs_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_func,
    input  logic                      in_new_case,
    input  logic [gbhs_pkg::VW-1:0]   in_place,
    input  logic [gbhs_pkg::VW-1:0]   in_amount,
    input  gbhs_pkg::cmd_t            cmd,
    output gbhs_pkg::stat_t           stat,
    output logic [gbhs_pkg::CW-1:0]   boosts_taken,
    output logic                      failed,
    output logic                      overflow
);
    import gbhs_pkg::*;

    logic [VW-1:0] mem [HEAP_DEPTH];
    logic [VW-1:0] rd_a_reg, rd_b_reg;
    logic [SW-1:0] size_reg, size_next;
    logic [PW-1:0] power_reg, power_next;
    logic [CW-1:0] count_reg, count_next;
    logic          fail_reg, fail_next, ovf_reg, ovf_next;
    logic          func_reg;
    logic [VW-1:0] val_reg;    // push value or sift-down last
    logic [VW+1:0] need_reg;   // amount - place + 2, 0 if not positive
    logic [SW-1:0] hole_reg, hole_next;
    logic          pop_wait_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;
    logic [VW-1:0] wr_data;
    logic [SW-1:0] parent, lchild, rchild, size_m1;
    logic          has_right, right_gt;
    logic [VW-1:0] big;
    logic [PW:0]   sum;
    logic [VW+1:0] need_calc;

    assign parent = (hole_reg - SW'(1)) >> 1;
    assign lchild = {hole_reg[SW-2:0], 1'b1};
    assign rchild = lchild + SW'(1);
    assign size_m1 = size_reg - SW'(1);
    assign has_right = rchild < size_reg;
    assign right_gt = has_right && (rd_b_reg > rd_a_reg);
    assign big = right_gt ? rd_b_reg : rd_a_reg;
    assign need_calc = {2'b00, in_amount} + (VW+2)'(2) - {2'b00, in_place};

    // memory: one write, two registered reads
    always_comb
    begin
        rd_a_addr = AW'(parent);
        rd_b_addr = AW'(rchild);
        if (cmd.pop_init)
        begin
            rd_a_addr = '0;
            rd_b_addr = AW'(size_m1);
        end
        else if (cmd.pop_rd)
            rd_a_addr = AW'(lchild);
        else if (cmd.push_rd)
            rd_a_addr = AW'(parent);
    end

    always_comb
    begin
        wr_en = cmd.push_move | cmd.push_done | cmd.pop_move | cmd.pop_done;
        wr_addr = AW'(hole_reg);
        wr_data = val_reg;
        if (cmd.push_move)
            wr_data = rd_a_reg;
        else if (cmd.pop_move)
            wr_data = big;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    // saturating add of popped top
    assign sum = {1'b0, power_reg} + {{(PW-VW+1){1'b0}}, rd_a_reg};

    // state updates
    always_comb
    begin
        size_next = size_reg;
        power_next = power_reg;
        count_next = count_reg;
        fail_next = fail_reg;
        ovf_next = ovf_reg;
        hole_next = hole_reg;
        if (cmd.load && in_new_case)
        begin
            size_next = '0;
            power_next = PW'(1);
            count_next = '0;
            fail_next = 1'b0;
            ovf_next = 1'b0;
        end
        if (cmd.set_fail)
            fail_next = 1'b1;
        if (cmd.set_ovf)
            ovf_next = 1'b1;
        if (cmd.push_init)
        begin
            hole_next = size_reg;
            size_next = size_reg + SW'(1);
        end
        if (cmd.push_move)
            hole_next = parent;
        if (cmd.pop_init)
        begin
            size_next = size_m1;
            hole_next = '0;
        end
        if (pop_wait_reg)
        begin
            power_next = sum[PW] ? POWER_MAX : sum[PW-1:0];
            if (count_reg != COUNT_MAX)
                count_next = count_reg + CW'(1);
        end
        if (cmd.pop_move)
            hole_next = right_gt ? rchild : lchild;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
            power_reg <= PW'(1);
            count_reg <= '0;
            fail_reg <= 1'b0;
            ovf_reg <= 1'b0;
            pop_wait_reg <= 1'b0;
        end
        else
        begin
            size_reg <= size_next;
            power_reg <= power_next;
            count_reg <= count_next;
            fail_reg <= fail_next;
            ovf_reg <= ovf_next;
            pop_wait_reg <= cmd.pop_init;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hole_reg <= hole_next;
        if (cmd.load)
        begin
            func_reg <= in_func;
            val_reg <= in_amount;
            need_reg <= need_calc[VW+1] ? '0 : need_calc;
        end
        else if (pop_wait_reg)
            val_reg <= rd_b_reg;
    end

    // status
    always_comb
    begin
        stat.is_hurdle = func_reg;
        stat.failed = fail_reg;
        stat.heap_full = size_reg == SW'(HEAP_DEPTH);
        stat.heap_empty = size_reg == '0;
        stat.power_short = power_reg < {{(PW-VW-2){1'b0}}, need_reg};
        stat.push_at_root = hole_reg == '0;
        stat.parent_ge = rd_a_reg >= val_reg;
        stat.pop_no_child = lchild >= size_reg;
        stat.child_le = big <= val_reg;
        stat.pop_last = size_reg == '0;
    end

    assign boosts_taken = count_reg;
    assign failed = fail_reg;
    assign overflow = ovf_reg;
endmodule

[rtl/greedy_boost_heap_scheduler.sv]
// greedy_boost_heap_scheduler: top level, request and result channels
// depends on gbhs_pkg, gbhs_if, gbhs_ctrl, gbhs_datapath
`timescale 1ns / 1ps
// One request in, one result out. A request after a failed hurdle goes
// straight to the result. A power-up into a full heap sets the overflow
// flag; otherwise it is pushed and moves up past each smaller parent
// until it reaches the root or a parent not below it. A hurdle pops the
// largest boost, adds it to power with saturation and moves the last entry
// down past larger children, for as long as power is short; it fails when
// the heap is empty and power is still short. The heap memory holds
// HEAP_DEPTH entries. The result is then held until taken, and a new
// request is taken once the result has been taken.
module greedy_boost_heap_scheduler (
    input logic clk,
    input logic rst_n,
    gbhs_if.sink   req,
    gbhs_if.source rsp
);
    import gbhs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    gbhs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .out_valid(rsp.valid),
        .out_ready(rsp.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbhs_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_func     (req.data.func),
        .in_new_case (req.data.new_case),
        .in_place    (req.data.place),
        .in_amount   (req.data.amount),
        .cmd         (cmd),
        .stat        (stat),
        .boosts_taken(rsp.data.boosts_taken),
        .failed      (rsp.data.failed),
        .overflow    (rsp.data.overflow)
    );
endmodule
